// ===== src/lfcd_pkg.sv =====
// Shared types, constants and the bytewise CRC-16/ARC update for the deframer.
package lfcd_pkg;

   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'h0000;
   localparam logic [16:0] HEADER_BYTES  = 17'd5;
   localparam logic [16:0] SESSION_BYTES = 17'd4;

   localparam logic [16:0] POS_START   = 17'd0;
   localparam logic [16:0] POS_COMMAND = 17'd2;
   localparam logic [16:0] POS_LEN_LO  = 17'd3;
   localparam logic [16:0] POS_LEN_HI  = 17'd4;

   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_ERROR_CODE   = 2'd2;
   localparam logic [1:0] CSR_STRIP        = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic [1:0] frame_status;
      logic [7:0] reply_command;
      logic       frame_last;
   } lfcd_result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/lfcd_frame_engine.sv =====
// Frame position tracking, CRC accumulation, config registers and result generation.
module lfcd_frame_engine
   import lfcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_write_data,
   input  logic            byte_accept,
   input  logic [7:0]      rx_byte,
   output logic            res_valid,
   output lfcd_result_type res
);

   logic [7:0]  start_marker_ff, end_marker_ff, error_code_ff;
   logic        strip_session_ff;

   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        start_ok_ff, start_ok_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic        strip_ff, strip_in;

   logic [16:0] off;
   logic [16:0] len_ext;
   logic [15:0] crc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= 8'hAA;
         end_marker_ff    <= 8'h55;
         error_code_ff    <= 8'hC9;
         strip_session_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff  <= csr_write_data;
            CSR_END_MARKER:   end_marker_ff    <= csr_write_data;
            CSR_ERROR_CODE:   error_code_ff    <= csr_write_data;
            CSR_STRIP:        strip_session_ff <= csr_write_data[0];
            default:          ;
         endcase
      end
   end

   assign off      = pos_ff - HEADER_BYTES;
   assign len_ext  = {1'b0, len_ff};
   assign crc_next = crc_byte(crc_ff, rx_byte);

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      rx_crc_in   = rx_crc_ff;
      start_ok_in = start_ok_ff;
      cmd_in      = cmd_ff;
      strip_in    = strip_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (byte_accept) begin
         if (pos_ff == POS_START) begin
            start_ok_in = (rx_byte == start_marker_ff);
            crc_in      = CRC_INIT;
            pos_in      = 17'd1;
         end else if (pos_ff < HEADER_BYTES) begin
            crc_in = crc_next;
            pos_in = pos_ff + 17'd1;
            if (pos_ff == POS_COMMAND) begin
               cmd_in = rx_byte;
            end else if (pos_ff == POS_LEN_LO) begin
               len_in = {8'h00, rx_byte};
            end else if (pos_ff == POS_LEN_HI) begin
               len_in   = {rx_byte, len_ff[7:0]};
               strip_in = strip_session_ff && ({1'b0, len_in} >= SESSION_BYTES);
            end
         end else if (off < len_ext) begin
            crc_in = crc_next;
            pos_in = pos_ff + 17'd1;
            if (!(strip_ff && off < SESSION_BYTES)) begin
               res_valid        = 1'b1;
               res.result_kind  = KIND_PAYLOAD;
               res.payload_byte = rx_byte;
            end
         end else if (off == len_ext) begin
            rx_crc_in = {8'h00, rx_byte};
            pos_in    = pos_ff + 17'd1;
         end else if (off == len_ext + 17'd1) begin
            rx_crc_in = {rx_byte, rx_crc_ff[7:0]};
            pos_in    = pos_ff + 17'd1;
         end else begin
            res_valid         = 1'b1;
            res.result_kind   = KIND_STATUS;
            res.reply_command = cmd_ff;
            res.frame_last    = 1'b1;
            if (!start_ok_ff || rx_byte != end_marker_ff || crc_ff != rx_crc_ff) begin
               res.frame_status = STATUS_MALFORMED;
            end else if (cmd_ff == error_code_ff) begin
               res.frame_status = STATUS_REJECTED;
            end else begin
               res.frame_status = STATUS_OK;
            end
            pos_in = POS_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_START;
         len_ff      <= '0;
         crc_ff      <= CRC_INIT;
         rx_crc_ff   <= '0;
         start_ok_ff <= 1'b0;
         cmd_ff      <= '0;
         strip_ff    <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         crc_ff      <= crc_in;
         rx_crc_ff   <= rx_crc_in;
         start_ok_ff <= start_ok_in;
         cmd_ff      <= cmd_in;
         strip_ff    <= strip_in;
      end
   end

`ifndef SYNTH
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ext + HEADER_BYTES + 17'd2)
      else $error("frame position past end of frame");
   a_status_resets_pos: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.frame_last) |=> pos_ff == POS_START)
      else $error("status result did not restart framing");
`endif

endmodule

// ===== src/lfcd_out_buffer.sv =====
// Result register with a one-entry skid stage between engine and response channel.
module lfcd_out_buffer
   import lfcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  lfcd_result_type in_res,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lfcd_result_type rsp_res
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   lfcd_result_type main_ff, main_in;
   lfcd_result_type skid_ff, skid_in;
   logic            main_free;

   assign main_free = !main_valid_ff || !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_res;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_res   = main_ff;

`ifndef SYNTH
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a result in the output register");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result arrived while skid stage full");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && rsp_stall) |=> (main_valid_ff && main_ff == $past(main_ff)))
      else $error("stalled response changed");
`endif

endmodule

// ===== src/length_framed_crc16_deframer_top.sv =====
// Top level of the length-framed CRC-16/ARC deframer.
//
// Input channel req_*: one received frame byte per transaction, accepted when
// req_valid is high and req_stall low. Frames are start, version, command,
// 16-bit little-endian length, payload, CRC-16/ARC (little-endian) and end;
// framing is by byte count only.
// Response channel rsp_*: payload bytes (rsp_result_kind 0) as they arrive,
// and one status transaction (rsp_frame_last 1) on the end byte. Payload goes
// out before the CRC check, so discard it when the status is not ok.
// Output: each result is registered before it shows on rsp_valid.
// Throughput: one byte per cycle while req_stall is low; the bytewise CRC
// update and position counter complete in the same cycle as the accept.
// Stall: a two-entry output stage (register plus skid) absorbs one result
// while rsp_stall is high; req_stall rises once the skid entry is occupied.
// Reset: synchronous; registers return to their defaults and framing waits
// for a start byte. csr_* writes take effect on the next cycle.
module length_framed_crc16_deframer_top
   import lfcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_frame_status,
   output logic [7:0] rsp_reply_command,
   output logic       rsp_frame_last
);

   logic            byte_accept;
   logic            res_valid;
   lfcd_result_type res;
   lfcd_result_type rsp_res;
   logic            buf_full;

   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !buf_full;

   lfcd_frame_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .byte_accept      (byte_accept),
      .rx_byte          (req_rx_byte),
      .res_valid        (res_valid),
      .res              (res)
   );

   lfcd_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_result_kind   = rsp_res.result_kind;
   assign rsp_payload_byte  = rsp_res.payload_byte;
   assign rsp_frame_status  = rsp_res.frame_status;
   assign rsp_reply_command = rsp_res.reply_command;
   assign rsp_frame_last    = rsp_res.frame_last;

endmodule
